/* src/ufs_pkg.sv */
// shared types, codes and character classes for the uri field splitter
package ufs_pkg;

  typedef enum logic [3:0] {
    PH_SCHEME0 = 4'd0,
    PH_SCHEME  = 4'd1,
    PH_SLASH1  = 4'd2,
    PH_SLASH2  = 4'd3,
    PH_DOMAIN0 = 4'd4,
    PH_DOMAIN  = 4'd5,
    PH_PORT0   = 4'd6,
    PH_PORT    = 4'd7,
    PH_PATH    = 4'd8,
    PH_QUERY   = 4'd9,
    PH_FRAG0   = 4'd10,
    PH_FRAG    = 4'd11,
    PH_REJECT  = 4'd12
  } phase_e;

  localparam logic [2:0] TAG_DELIM  = 3'd0;
  localparam logic [2:0] TAG_SCHEME = 3'd1;
  localparam logic [2:0] TAG_DOMAIN = 3'd2;
  localparam logic [2:0] TAG_PORT   = 3'd3;
  localparam logic [2:0] TAG_PATH   = 3'd4;
  localparam logic [2:0] TAG_QUERY  = 3'd5;
  localparam logic [2:0] TAG_FRAG   = 3'd6;
  localparam logic [2:0] TAG_REJECT = 3'd7;

  localparam logic [7:0] CH_COLON    = 8'd58;
  localparam logic [7:0] CH_SLASH    = 8'd47;
  localparam logic [7:0] CH_DOT      = 8'd46;
  localparam logic [7:0] CH_HYPHEN   = 8'd45;
  localparam logic [7:0] CH_QUESTION = 8'd63;
  localparam logic [7:0] CH_HASH     = 8'd35;
  localparam logic [7:0] CH_EQUAL    = 8'd61;
  localparam logic [7:0] CH_AMP      = 8'd38;
  localparam logic [7:0] CH_UNDER    = 8'd95;

  localparam logic [15:0] PORT_MAX = 16'hffff;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] port_acc;
    logic        port_ovf;
    logic        path_seen;
    logic        port_seen;
  } state_t;

  typedef struct packed {
    logic [2:0]  field_tag;
    logic        string_done;
    logic        match_ok;
    logic        has_port;
    logic [15:0] port_number;
    logic        port_clipped;
    logic        has_path;
    logic        has_query;
    logic        has_fragment;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:     PH_SCHEME0,
    port_acc:  16'd0,
    port_ovf:  1'b0,
    path_seen: 1'b0,
    port_seen: 1'b0
  };

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'd48:8'd57]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122]}) || (c == CH_UNDER);
  endfunction

  function automatic logic is_domain_ch(input logic [7:0] c);
    return is_word(c) || (c == CH_DOT) || (c == CH_HYPHEN);
  endfunction

  function automatic logic is_path_ch(input logic [7:0] c);
    return is_word(c) || (c == CH_SLASH) || (c == CH_DOT);
  endfunction

  function automatic logic is_query_ch(input logic [7:0] c);
    return is_word(c) || (c == CH_EQUAL) || (c == CH_AMP);
  endfunction

endpackage

/* src/ufs_step.sv */
// next parse state and result for one byte
module ufs_step (
  input  ufs_pkg::state_t  state_i,
  input  logic [7:0]       char_code_i,
  input  logic             final_char_i,
  output ufs_pkg::state_t  state_o,
  output ufs_pkg::result_t result_o
);

  ufs_pkg::state_t nxt;
  ufs_pkg::phase_e np;
  logic [2:0]      tag;
  logic [19:0]     prod;
  logic            ok;
  logic            qry;
  logic            frg;

  assign prod = ({4'd0, state_i.port_acc} << 3) + ({4'd0, state_i.port_acc} << 1)
              + {16'd0, char_code_i[3:0]};

  always_comb begin
    nxt = state_i;
    np  = ufs_pkg::PH_REJECT;
    tag = ufs_pkg::TAG_REJECT;
    case (state_i.phase)
      ufs_pkg::PH_SCHEME0: begin
        if (ufs_pkg::is_word(char_code_i)) begin
          np = ufs_pkg::PH_SCHEME; tag = ufs_pkg::TAG_SCHEME;
        end
      end
      ufs_pkg::PH_SCHEME: begin
        if (ufs_pkg::is_word(char_code_i)) begin
          np = ufs_pkg::PH_SCHEME; tag = ufs_pkg::TAG_SCHEME;
        end else if (char_code_i == ufs_pkg::CH_COLON) begin
          np = ufs_pkg::PH_SLASH1; tag = ufs_pkg::TAG_DELIM;
        end
      end
      ufs_pkg::PH_SLASH1: begin
        if (char_code_i == ufs_pkg::CH_SLASH) begin
          np = ufs_pkg::PH_SLASH2; tag = ufs_pkg::TAG_DELIM;
        end
      end
      ufs_pkg::PH_SLASH2: begin
        if (char_code_i == ufs_pkg::CH_SLASH) begin
          np = ufs_pkg::PH_DOMAIN0; tag = ufs_pkg::TAG_DELIM;
        end
      end
      ufs_pkg::PH_DOMAIN0: begin
        if (ufs_pkg::is_domain_ch(char_code_i)) begin
          np = ufs_pkg::PH_DOMAIN; tag = ufs_pkg::TAG_DOMAIN;
        end
      end
      ufs_pkg::PH_DOMAIN: begin
        if (ufs_pkg::is_domain_ch(char_code_i)) begin
          np = ufs_pkg::PH_DOMAIN; tag = ufs_pkg::TAG_DOMAIN;
        end else if (char_code_i == ufs_pkg::CH_COLON) begin
          np = ufs_pkg::PH_PORT0; tag = ufs_pkg::TAG_DELIM;
        end else if (char_code_i == ufs_pkg::CH_SLASH) begin
          np = ufs_pkg::PH_PATH; tag = ufs_pkg::TAG_PATH; nxt.path_seen = 1'b1;
        end else if (char_code_i == ufs_pkg::CH_QUESTION) begin
          np = ufs_pkg::PH_QUERY; tag = ufs_pkg::TAG_DELIM;
        end
      end
      ufs_pkg::PH_PORT0, ufs_pkg::PH_PORT: begin
        if (ufs_pkg::is_digit(char_code_i)) begin
          if (prod > {4'd0, ufs_pkg::PORT_MAX}) begin
            nxt.port_acc = ufs_pkg::PORT_MAX;
            nxt.port_ovf = 1'b1;
          end else begin
            nxt.port_acc = prod[15:0];
          end
          nxt.port_seen = 1'b1;
          np = ufs_pkg::PH_PORT; tag = ufs_pkg::TAG_PORT;
        end else if (state_i.phase == ufs_pkg::PH_PORT && ufs_pkg::is_path_ch(char_code_i)) begin
          np = ufs_pkg::PH_PATH; tag = ufs_pkg::TAG_PATH; nxt.path_seen = 1'b1;
        end else if (state_i.phase == ufs_pkg::PH_PORT && char_code_i == ufs_pkg::CH_QUESTION) begin
          np = ufs_pkg::PH_QUERY; tag = ufs_pkg::TAG_DELIM;
        end
      end
      ufs_pkg::PH_PATH: begin
        if (ufs_pkg::is_path_ch(char_code_i)) begin
          np = ufs_pkg::PH_PATH; tag = ufs_pkg::TAG_PATH;
        end else if (char_code_i == ufs_pkg::CH_QUESTION) begin
          np = ufs_pkg::PH_QUERY; tag = ufs_pkg::TAG_DELIM;
        end
      end
      ufs_pkg::PH_QUERY: begin
        if (ufs_pkg::is_query_ch(char_code_i)) begin
          np = ufs_pkg::PH_QUERY; tag = ufs_pkg::TAG_QUERY;
        end else if (char_code_i == ufs_pkg::CH_HASH) begin
          np = ufs_pkg::PH_FRAG0; tag = ufs_pkg::TAG_DELIM;
        end
      end
      ufs_pkg::PH_FRAG0, ufs_pkg::PH_FRAG: begin
        if (ufs_pkg::is_word(char_code_i)) begin
          np = ufs_pkg::PH_FRAG; tag = ufs_pkg::TAG_FRAG;
        end
      end
      default: begin
        np = ufs_pkg::PH_REJECT;
      end
    endcase
    nxt.phase = np;
  end

  assign ok  = np inside {ufs_pkg::PH_DOMAIN, ufs_pkg::PH_PORT, ufs_pkg::PH_PATH,
                          ufs_pkg::PH_QUERY, ufs_pkg::PH_FRAG};
  assign qry = (np == ufs_pkg::PH_QUERY) || (np == ufs_pkg::PH_FRAG);
  assign frg = (np == ufs_pkg::PH_FRAG);

  always_comb begin
    result_o           = '0;
    result_o.field_tag = tag;
    if (final_char_i) begin
      result_o.string_done = 1'b1;
      if (ok) begin
        result_o.match_ok     = 1'b1;
        result_o.has_port     = nxt.port_seen;
        result_o.port_number  = nxt.port_seen ? nxt.port_acc : 16'd0;
        result_o.port_clipped = nxt.port_seen & nxt.port_ovf;
        result_o.has_path     = nxt.path_seen;
        result_o.has_query    = qry;
        result_o.has_fragment = frg;
      end
    end
  end

  assign state_o = final_char_i ? ufs_pkg::STATE_RESET : nxt;

endmodule

/* src/uri_field_splitter.sv */
// top level of the uri field splitter
//
// input channel: one byte of uri text per item (char_code_i) with final_char_i
// marking the last byte of a string; in_valid_i / in_stall_o.
// output channel: one result item per input item; out_valid_o / out_stall_i.
// every byte gets a field tag; the item for the last byte also carries
// string_done_o, match_ok_o, the presence flags and the decimal port value,
// saturated at 65535 with port_clipped_o raised.
// an item passes through the input register and then the result register;
// throughput is one item per cycle while the receiver does not stall, set by
// the single parse step between the two registers.
// a new item is taken while a finished result waits in the result register;
// when the receiver stalls, the result holds and the input register fills,
// after which in_stall_o is raised until the output moves again.
// after the last byte of a string the parser is back at the start of a
// scheme, ready for the next string.
// reset empties both registers and puts the parser at the start of a scheme.
module uri_field_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        final_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  field_tag_o,
  output logic        string_done_o,
  output logic        match_ok_o,
  output logic        has_port_o,
  output logic [15:0] port_number_o,
  output logic        port_clipped_o,
  output logic        has_path_o,
  output logic        has_query_o,
  output logic        has_fragment_o
);

  logic             in_valid_q;
  logic [7:0]       char_q;
  logic             last_q;
  logic             out_valid_q;
  ufs_pkg::result_t res_q;
  ufs_pkg::result_t res_d;
  ufs_pkg::state_t  state_q;
  ufs_pkg::state_t  state_d;
  logic             advance;
  logic             in_load;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  ufs_step u_step (
    .state_i      (state_q),
    .char_code_i  (char_q),
    .final_char_i (last_q),
    .state_o      (state_d),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ufs_pkg::STATE_RESET;
    end else begin
      if (!in_valid_q || advance) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      char_q <= char_code_i;
      last_q <= final_char_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign field_tag_o    = res_q.field_tag;
  assign string_done_o  = res_q.string_done;
  assign match_ok_o     = res_q.match_ok;
  assign has_port_o     = res_q.has_port;
  assign port_number_o  = res_q.port_number;
  assign port_clipped_o = res_q.port_clipped;
  assign has_path_o     = res_q.has_path;
  assign has_query_o    = res_q.has_query;
  assign has_fragment_o = res_q.has_fragment;

  a_summary_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !string_done_o |-> !match_ok_o && !has_query_o && !has_port_o)
    else $error("summary flags outside last item");

  a_match_not_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_ok_o |-> field_tag_o != ufs_pkg::TAG_REJECT)
    else $error("matched string ends on rejected byte");

  a_no_port_no_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_port_o |-> port_number_o == 16'd0 && !port_clipped_o)
    else $error("port value without port");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q |=> state_q.phase == ufs_pkg::PH_SCHEME0 && !state_q.port_seen)
    else $error("parser not restarted after last byte");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked item");

endmodule
